// ----- rtl/battery_level_hysteresis_debounce_defines.svh -----
// Assertion macros shared by the battery level monitor checkers.
// Depends on nothing; expects signals clk and rst in the scope of use.
`ifndef BATTERY_LEVEL_HYSTERESIS_DEBOUNCE_DEFINES_SVH
`define BATTERY_LEVEL_HYSTERESIS_DEBOUNCE_DEFINES_SVH

// Same-cycle implication, masked during reset.
`define BLD_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("battery level check failed");

// Next-cycle implication, masked during reset.
`define BLD_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("battery level check failed");

// State right after a reset cycle.
`define BLD_ASSERT_RST(label, cons) \
  label: assert property (@(posedge clk) rst |=> (cons)) \
    else $error("battery level reset check failed");

`endif

// ----- rtl/bld_pkg.sv -----
// Shared types and constants for the battery level monitor.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps

package bld_pkg;

  // Level codes
  localparam logic [2:0] LVL_ULTRALOW  = 3'd0;
  localparam logic [2:0] LVL_LOW       = 3'd1;
  localparam logic [2:0] LVL_NORMAL    = 3'd2;
  localparam logic [2:0] LVL_HIGH      = 3'd3;
  localparam logic [2:0] LVL_ULTRAHIGH = 3'd4;

  localparam int unsigned LEVEL_COUNT = 5;

  // Configuration register indexes
  typedef enum logic [3:0] {
    CFG_ENABLE         = 4'd0,
    CFG_WIN_ULTRALOW   = 4'd1,
    CFG_WIN_LOW        = 4'd2,
    CFG_WIN_NORMAL     = 4'd3,
    CFG_WIN_HIGH       = 4'd4,
    CFG_WIN_ULTRAHIGH  = 4'd5,
    CFG_THRESHOLDS     = 4'd6,
    CFG_RELOAD         = 4'd7
  } cfg_index_t;

  localparam logic [63:0] THRESH_RESET = 64'h0708_0640_03E8_0384;
  localparam logic [7:0]  RELOAD_RESET = 8'd3;

  typedef struct packed {
    logic [15:0] sample_voltage;
    logic        sample_ok;
  } in_item_t;

  typedef struct packed {
    logic [15:0] held_voltage;
    logic [2:0]  battery_level;
    logic        level_changed;
  } out_item_t;

  // Register file contents as seen by the level logic
  typedef struct packed {
    logic                          enable;
    logic [LEVEL_COUNT-1:0][31:0]  window;
    logic [3:0][15:0]              thresh;
    logic [7:0]                    reload;
  } cfg_t;

endpackage

// ----- rtl/battery_level_hysteresis_debounce.sv -----
// Battery level monitor: takes one voltage sample (hundredths of a volt) and a
// read-success flag per transfer and returns one result with the held voltage,
// the five-way battery level and a level-change flag. It accepts one sample
// every cycle unless in_stall is raised by a stalled result; a sample lands in
// the input register when accepted, and its result is computed from it and
// loaded into the result register once that register is free; the level/debounce
// state loop closes through the compare and counter logic. A stalled result holds
// while one more sample waits in the input register. The configuration port is
// always ready; write it only while no sample is in flight.
// Depends on bld_pkg, bld_cfg_regs and bld_level_fsm.
`timescale 1ns / 1ps

module battery_level_hysteresis_debounce (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  input  bld_pkg::in_item_t   in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output bld_pkg::out_item_t  out_data,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [3:0]          cfg_index,
  input  logic [63:0]         cfg_data
);
  import bld_pkg::*;

  cfg_t      cfg;
  in_item_t  s1_data;
  logic      s1_valid;
  logic      out_free;
  logic      advance;
  out_item_t result;

  assign cfg_ready = 1'b1;
  assign out_free  = !out_valid || !out_stall;
  assign advance   = s1_valid && out_free;
  assign in_stall  = s1_valid && !out_free;

  bld_cfg_regs u_cfg (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (cfg_valid && cfg_ready),
    .wr_index (cfg_index),
    .wr_data  (cfg_data),
    .cfg      (cfg)
  );

  bld_level_fsm u_fsm (
    .clk     (clk),
    .rst     (rst),
    .cfg     (cfg),
    .advance (advance),
    .item    (s1_data),
    .result  (result)
  );

  // Input register: take a transfer whenever it is not held
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (!in_stall) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall && in_valid) begin
      s1_data <= in_data;
    end
  end

  // Result register: load on advance, drop after the transfer out
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_free) begin
      out_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_data <= result;
    end
  end

endmodule

// ----- rtl/bld_cfg_regs.sv -----
// Configuration register file of the battery level monitor.
// Depends on bld_pkg for register indexes and the cfg_t bundle.
`timescale 1ns / 1ps

module bld_cfg_regs (
  input  logic                clk,
  input  logic                rst,
  input  logic                wr_en,
  input  logic [3:0]          wr_index,
  input  logic [63:0]         wr_data,
  output bld_pkg::cfg_t       cfg
);
  import bld_pkg::*;

  // Decode and store one register per write transfer
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.enable <= 1'b0;
      cfg.window <= '0;
      cfg.thresh <= THRESH_RESET;
      cfg.reload <= RELOAD_RESET;
    end else if (wr_en) begin
      unique case (wr_index)
        CFG_ENABLE:        cfg.enable    <= wr_data[0];
        CFG_WIN_ULTRALOW:  cfg.window[0] <= wr_data[31:0];
        CFG_WIN_LOW:       cfg.window[1] <= wr_data[31:0];
        CFG_WIN_NORMAL:    cfg.window[2] <= wr_data[31:0];
        CFG_WIN_HIGH:      cfg.window[3] <= wr_data[31:0];
        CFG_WIN_ULTRAHIGH: cfg.window[4] <= wr_data[31:0];
        CFG_THRESHOLDS:    cfg.thresh    <= wr_data;
        CFG_RELOAD:        cfg.reload    <= wr_data[7:0];
        default: ;
      endcase
    end
  end

endmodule

// ----- rtl/bld_level_fsm.sv -----
// Hysteresis window check, five-level classifier and debounce state.
// Depends on bld_pkg; state advances once per transfer into the result stage.
`timescale 1ns / 1ps

module bld_level_fsm (
  input  logic                clk,
  input  logic                rst,
  input  bld_pkg::cfg_t       cfg,
  input  logic                advance,
  input  bld_pkg::in_item_t   item,
  output bld_pkg::out_item_t  result
);
  import bld_pkg::*;

  logic [2:0]  level;
  logic [15:0] voltage;
  logic [7:0]  count;

  logic [2:0]  level_next;
  logic [15:0] voltage_next;
  logic [7:0]  count_next;

  logic [31:0] win;
  logic [15:0] win_start;
  logic [15:0] win_end;
  logic [2:0]  cand;
  logic [7:0]  count_dec;
  logic        update;
  logic        outside;
  logic        changed;

  // Select the window of the reported level
  always_comb begin
    case (level)
      LVL_ULTRALOW:  win = cfg.window[0];
      LVL_LOW:       win = cfg.window[1];
      LVL_HIGH:      win = cfg.window[3];
      LVL_ULTRAHIGH: win = cfg.window[4];
      default:       win = cfg.window[2];
    endcase
  end

  assign win_start = win[15:0];
  assign win_end   = win[31:16];

  // Classify against the ordered thresholds
  always_comb begin
    if (item.sample_voltage < cfg.thresh[0])      cand = LVL_ULTRALOW;
    else if (item.sample_voltage < cfg.thresh[1]) cand = LVL_LOW;
    else if (item.sample_voltage < cfg.thresh[2]) cand = LVL_NORMAL;
    else if (item.sample_voltage < cfg.thresh[3]) cand = LVL_HIGH;
    else                                          cand = LVL_ULTRAHIGH;
  end

  assign update    = cfg.enable && item.sample_ok;
  assign outside   = (item.sample_voltage <= win_start) || (item.sample_voltage >= win_end);
  assign count_dec = (count != 8'd0) ? count - 8'd1 : 8'd0;

  // Debounce: count down, switch at zero, reload on agreement
  always_comb begin
    level_next   = level;
    voltage_next = voltage;
    count_next   = count;
    changed      = 1'b0;
    if (update) begin
      voltage_next = item.sample_voltage;
      if (outside) begin
        count_next = count_dec;
        if (count_dec == 8'd0 && level != cand) begin
          level_next = cand;
          changed    = 1'b1;
        end
        if (cand == level_next) begin
          count_next = cfg.reload;
        end
      end
    end
  end

  assign result.held_voltage  = voltage_next;
  assign result.battery_level = level_next;
  assign result.level_changed = changed;

  // Hold state between transfers
  always_ff @(posedge clk) begin
    if (rst) begin
      level   <= LVL_NORMAL;
      voltage <= 16'd0;
      count   <= RELOAD_RESET;
    end else if (advance) begin
      level   <= level_next;
      voltage <= voltage_next;
      count   <= count_next;
    end
  end

endmodule

// ----- rtl/bld_checker.sv -----
// Port-level checks for the battery level monitor, bound to the top level.
// Depends on bld_pkg and the assertion macros header.
`timescale 1ns / 1ps

`include "battery_level_hysteresis_debounce_defines.svh"

module bld_checker (
  input logic                clk,
  input logic                rst,
  input logic                in_stall,
  input logic                out_valid,
  input logic                out_stall,
  input bld_pkg::out_item_t  out_data
);
  import bld_pkg::*;

  // A stalled result holds
  `BLD_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_data))

  // Reported level is one of the five codes
  `BLD_ASSERT_NOW(a_level_range, out_valid, out_data.battery_level <= LVL_ULTRAHIGH)

  // Input back-pressure only comes from a stalled result
  `BLD_ASSERT_NOW(a_stall_cause, in_stall, out_valid && out_stall)

  // Nothing pending right after reset
  `BLD_ASSERT_RST(a_reset_empty, !out_valid && !in_stall)

endmodule

bind battery_level_hysteresis_debounce bld_checker u_bld_checker (.*);
